/* rtl/jtdp_pkg.sv */
// Package for the JVM type descriptor parser: transfer structs, the phase
// encoding, type, role and status codes, and the descriptor letters.
// Depends on nothing; every other file uses it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package jtdp_pkg;

    typedef struct packed {
        logic       mode;
        logic [7:0] character;
        logic       no_char;
        logic       last;
    } t_in;

    typedef struct packed {
        logic [3:0] type_code;
        logic [1:0] role;
        logic [7:0] consumed_length;
        logic [3:0] status;
        logic       final_res;
    } t_out;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_FSTART = 4'd1,
        PH_FELEM  = 4'd2,
        PH_FCLASS = 4'd3,
        PH_FDONE  = 4'd4,
        PH_FERR   = 4'd5,
        PH_MSTART = 4'd6,
        PH_MARG   = 4'd7,
        PH_MELEM  = 4'd8,
        PH_MCLASS = 4'd9,
        PH_MSKIP  = 4'd10,
        PH_RSTART = 4'd11,
        PH_RELEM  = 4'd12,
        PH_RCLASS = 4'd13,
        PH_RDONE  = 4'd14,
        PH_HALT   = 4'd15
    } t_phase;

    localparam logic [3:0] TC_CLASS = 4'd8;
    localparam logic [3:0] TC_ARRAY = 4'd9;
    localparam logic [3:0] TC_VOID  = 4'd10;
    localparam logic [3:0] TC_NONE  = 4'd15;
    localparam logic [3:0] TC_MAX   = 4'd10;

    localparam logic [1:0] ROLE_ARG    = 2'd0;
    localparam logic [1:0] ROLE_RETURN = 2'd1;
    localparam logic [1:0] ROLE_FIELD  = 2'd2;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_EMPTY     = 4'd1;
    localparam logic [3:0] ST_NO_LBRACE = 4'd2;
    localparam logic [3:0] ST_NO_RBRACE = 4'd3;
    localparam logic [3:0] ST_NO_RETURN = 4'd4;
    localparam logic [3:0] ST_BAD_REF   = 4'd5;
    localparam logic [3:0] ST_BAD_ARRAY = 4'd6;
    localparam logic [3:0] ST_UNRECOG   = 4'd7;
    localparam logic [3:0] ST_TAIL      = 4'd8;
    localparam logic [3:0] ST_MAX       = 4'd8;

    localparam logic [7:0] CH_BYTE   = 8'h42;
    localparam logic [7:0] CH_CHAR   = 8'h43;
    localparam logic [7:0] CH_DOUBLE = 8'h44;
    localparam logic [7:0] CH_FLOAT  = 8'h46;
    localparam logic [7:0] CH_INT    = 8'h49;
    localparam logic [7:0] CH_LONG   = 8'h4A;
    localparam logic [7:0] CH_SHORT  = 8'h53;
    localparam logic [7:0] CH_BOOL   = 8'h5A;
    localparam logic [7:0] CH_VOID   = 8'h56;
    localparam logic [7:0] CH_CLASS  = 8'h4C;
    localparam logic [7:0] CH_ARRAY  = 8'h5B;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;

    function automatic logic [3:0] prim_code(input logic [7:0] c);
        logic [3:0] r;
        case (c)
            CH_BYTE:   r = 4'd0;
            CH_CHAR:   r = 4'd1;
            CH_DOUBLE: r = 4'd2;
            CH_FLOAT:  r = 4'd3;
            CH_INT:    r = 4'd4;
            CH_LONG:   r = 4'd5;
            CH_SHORT:  r = 4'd6;
            CH_BOOL:   r = 4'd7;
            default:   r = TC_NONE;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/jvm_type_descriptor_parser.sv */
// Top level of the JVM field and method descriptor parser.
// Depends on jtdp_pkg for the transfer structs, phase encoding and codes.
//
//   channel   direction  handshake           payload
//   input     in         i_valid / o_stall   i_data  (jtdp_pkg::t_in)
//   result    out        o_valid / i_stall   o_data  (jtdp_pkg::t_out)
//
// Each character passes through the input register and one parse step;
// a new transfer is taken every cycle while results keep draining.
// A result reaches the result register after its input has left the input register.
// The rate is set by the single parse step between the input register and
// the result register. A stalled result register holds the parse step back.
// Reset returns the parser to the start of a descriptor with both registers empty.
`timescale 1ns / 1ps
`default_nettype none

module jvm_type_descriptor_parser #(
    parameter int unsigned MAX_LEN = 255
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    output logic            o_stall,
    input  jtdp_pkg::t_in   i_data,
    output logic            o_valid,
    input  wire             i_stall,
    output jtdp_pkg::t_out  o_data
);

    localparam int unsigned POS_W = $clog2(MAX_LEN + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LEN);

    logic              r_in_valid;
    jtdp_pkg::t_in     r_in;
    logic              r_out_valid;
    jtdp_pkg::t_out    r_out;

    logic              r_mode;
    jtdp_pkg::t_phase  r_phase;
    logic              r_in_array;
    logic [POS_W-1:0]  r_position;
    logic [3:0]        r_first_error;
    logic [3:0]        r_ret_type;
    logic [3:0]        r_ret_status;
    logic [3:0]        r_field_type;

    logic              n_mode;
    jtdp_pkg::t_phase  n_phase;
    logic              n_in_array;
    logic [POS_W-1:0]  n_position;
    logic [3:0]        n_first_error;
    logic [3:0]        n_ret_type;
    logic [3:0]        n_ret_status;
    logic [3:0]        n_field_type;
    jtdp_pkg::t_out    n_out;
    logic              w_emit;

    logic              w_advance;
    logic              w_in_load;
    jtdp_pkg::t_phase  w_ph;
    logic [7:0]        w_c;
    logic [3:0]        w_p;
    logic              w_is_prim;
    logic              w_arg_done;
    logic [3:0]        w_typ;
    logic [3:0]        w_st;

    assign w_advance = r_in_valid && (!r_out_valid || !i_stall);
    assign w_in_load = !r_in_valid || w_advance;
    assign o_stall   = !w_in_load;
    assign o_valid   = r_out_valid;
    assign o_data    = r_out;

    assign w_c       = r_in.character;
    assign w_p       = jtdp_pkg::prim_code(r_in.character);
    assign w_is_prim = (w_p != jtdp_pkg::TC_NONE);

    always_comb begin
        n_mode        = r_mode;
        n_phase       = r_phase;
        n_in_array    = r_in_array;
        n_position    = r_position;
        n_first_error = r_first_error;
        n_ret_type    = r_ret_type;
        n_ret_status  = r_ret_status;
        n_field_type  = r_field_type;
        w_arg_done    = 1'b0;
        w_typ         = '0;
        w_st          = jtdp_pkg::ST_OK;
        n_out         = '0;
        w_emit        = 1'b0;

        if (r_phase == jtdp_pkg::PH_IDLE) begin
            n_mode  = r_in.mode;
            n_phase = r_in.mode ? jtdp_pkg::PH_MSTART : jtdp_pkg::PH_FSTART;
        end
        w_ph = n_phase;

        if (!r_in.no_char) begin
            if (n_mode) begin
                unique case (w_ph)
                    jtdp_pkg::PH_MSTART: begin
                        if (w_c == jtdp_pkg::CH_LPAREN) begin
                            n_phase = jtdp_pkg::PH_MARG;
                        end else begin
                            n_first_error = jtdp_pkg::ST_NO_LBRACE;
                            n_phase       = jtdp_pkg::PH_HALT;
                        end
                    end
                    jtdp_pkg::PH_MARG, jtdp_pkg::PH_MELEM: begin
                        if (w_c == jtdp_pkg::CH_RPAREN) begin
                            if (w_ph == jtdp_pkg::PH_MELEM) begin
                                n_first_error = jtdp_pkg::ST_BAD_ARRAY;
                            end
                            n_in_array = 1'b0;
                            n_phase    = jtdp_pkg::PH_RSTART;
                        end else if (w_is_prim) begin
                            w_typ      = r_in_array ? jtdp_pkg::TC_ARRAY : w_p;
                            w_arg_done = 1'b1;
                            n_in_array = 1'b0;
                            n_phase    = jtdp_pkg::PH_MARG;
                        end else if (w_c == jtdp_pkg::CH_CLASS) begin
                            n_phase = jtdp_pkg::PH_MCLASS;
                        end else if (w_c == jtdp_pkg::CH_ARRAY) begin
                            n_in_array = 1'b1;
                            n_phase    = jtdp_pkg::PH_MELEM;
                        end else begin
                            n_first_error = r_in_array ? jtdp_pkg::ST_BAD_ARRAY
                                                       : jtdp_pkg::ST_UNRECOG;
                            n_in_array    = 1'b0;
                            n_phase       = jtdp_pkg::PH_MSKIP;
                        end
                    end
                    jtdp_pkg::PH_MCLASS: begin
                        if (w_c == jtdp_pkg::CH_RPAREN) begin
                            n_first_error = r_in_array ? jtdp_pkg::ST_BAD_ARRAY
                                                       : jtdp_pkg::ST_BAD_REF;
                            n_in_array    = 1'b0;
                            n_phase       = jtdp_pkg::PH_RSTART;
                        end else if (w_c == jtdp_pkg::CH_SEMI) begin
                            w_typ      = r_in_array ? jtdp_pkg::TC_ARRAY : jtdp_pkg::TC_CLASS;
                            w_arg_done = 1'b1;
                            n_in_array = 1'b0;
                            n_phase    = jtdp_pkg::PH_MARG;
                        end
                    end
                    jtdp_pkg::PH_MSKIP: begin
                        if (w_c == jtdp_pkg::CH_RPAREN) begin
                            n_phase = jtdp_pkg::PH_RSTART;
                        end
                    end
                    jtdp_pkg::PH_RSTART, jtdp_pkg::PH_RELEM: begin
                        if (w_ph == jtdp_pkg::PH_RSTART && w_c == jtdp_pkg::CH_VOID) begin
                            n_ret_type = jtdp_pkg::TC_VOID;
                            n_phase    = jtdp_pkg::PH_RDONE;
                        end else if (w_is_prim) begin
                            n_ret_type = r_in_array ? jtdp_pkg::TC_ARRAY : w_p;
                            n_phase    = jtdp_pkg::PH_RDONE;
                        end else if (w_c == jtdp_pkg::CH_CLASS) begin
                            n_phase = jtdp_pkg::PH_RCLASS;
                        end else if (w_c == jtdp_pkg::CH_ARRAY) begin
                            n_in_array = 1'b1;
                            n_phase    = jtdp_pkg::PH_RELEM;
                        end else begin
                            n_ret_status = r_in_array ? jtdp_pkg::ST_BAD_ARRAY
                                                      : jtdp_pkg::ST_UNRECOG;
                            n_phase      = jtdp_pkg::PH_HALT;
                        end
                    end
                    jtdp_pkg::PH_RCLASS: begin
                        if (w_c == jtdp_pkg::CH_SEMI) begin
                            n_ret_type = r_in_array ? jtdp_pkg::TC_ARRAY : jtdp_pkg::TC_CLASS;
                            n_phase    = jtdp_pkg::PH_RDONE;
                        end
                    end
                    jtdp_pkg::PH_RDONE: begin
                        n_ret_status = (r_ret_type == jtdp_pkg::TC_VOID) ?
                                       jtdp_pkg::ST_UNRECOG : jtdp_pkg::ST_TAIL;
                        n_phase      = jtdp_pkg::PH_HALT;
                    end
                    default: begin
                    end
                endcase
            end else begin
                if (w_ph == jtdp_pkg::PH_FSTART || w_ph == jtdp_pkg::PH_FELEM) begin
                    if (r_position < POS_MAX) begin
                        n_position = r_position + 1'b1;
                    end
                    if (w_is_prim) begin
                        n_field_type = r_in_array ? jtdp_pkg::TC_ARRAY : w_p;
                        n_phase      = jtdp_pkg::PH_FDONE;
                    end else if (w_c == jtdp_pkg::CH_CLASS) begin
                        n_phase = jtdp_pkg::PH_FCLASS;
                    end else if (w_c == jtdp_pkg::CH_ARRAY) begin
                        n_in_array = 1'b1;
                        n_phase    = jtdp_pkg::PH_FELEM;
                    end else begin
                        n_first_error = r_in_array ? jtdp_pkg::ST_BAD_ARRAY
                                                   : jtdp_pkg::ST_UNRECOG;
                        n_phase       = jtdp_pkg::PH_FERR;
                    end
                end else if (w_ph == jtdp_pkg::PH_FCLASS) begin
                    if (r_position < POS_MAX) begin
                        n_position = r_position + 1'b1;
                    end
                    if (w_c == jtdp_pkg::CH_SEMI) begin
                        n_field_type = r_in_array ? jtdp_pkg::TC_ARRAY : jtdp_pkg::TC_CLASS;
                        n_phase      = jtdp_pkg::PH_FDONE;
                    end
                end
            end
        end

        if (r_in.last) begin
            w_emit = 1'b1;
            n_out.final_res = 1'b1;
            if (!n_mode) begin
                unique case (n_phase)
                    jtdp_pkg::PH_FSTART: w_st = jtdp_pkg::ST_EMPTY;
                    jtdp_pkg::PH_FELEM:  w_st = jtdp_pkg::ST_BAD_ARRAY;
                    jtdp_pkg::PH_FCLASS: w_st = n_in_array ? jtdp_pkg::ST_BAD_ARRAY
                                                           : jtdp_pkg::ST_BAD_REF;
                    jtdp_pkg::PH_FDONE:  w_st = jtdp_pkg::ST_OK;
                    default:             w_st = n_first_error;
                endcase
                n_out.role   = jtdp_pkg::ROLE_FIELD;
                n_out.status = w_st;
                if (w_st == jtdp_pkg::ST_OK) begin
                    n_out.type_code       = n_field_type;
                    n_out.consumed_length = 8'(n_position);
                end
            end else begin
                unique case (n_phase)
                    jtdp_pkg::PH_MSTART: w_st = jtdp_pkg::ST_EMPTY;
                    jtdp_pkg::PH_MARG, jtdp_pkg::PH_MELEM,
                    jtdp_pkg::PH_MCLASS, jtdp_pkg::PH_MSKIP:
                        w_st = jtdp_pkg::ST_NO_RBRACE;
                    jtdp_pkg::PH_RSTART: w_st = jtdp_pkg::ST_NO_RETURN;
                    jtdp_pkg::PH_RELEM:
                        w_st = (n_first_error != jtdp_pkg::ST_OK) ? n_first_error
                                                                   : jtdp_pkg::ST_BAD_ARRAY;
                    jtdp_pkg::PH_RCLASS:
                        w_st = (n_first_error != jtdp_pkg::ST_OK) ? n_first_error :
                               (n_in_array ? jtdp_pkg::ST_BAD_ARRAY : jtdp_pkg::ST_BAD_REF);
                    jtdp_pkg::PH_RDONE:  w_st = n_first_error;
                    default:
                        w_st = (n_first_error != jtdp_pkg::ST_OK) ? n_first_error
                                                                   : n_ret_status;
                endcase
                n_out.role   = jtdp_pkg::ROLE_RETURN;
                n_out.status = w_st;
                if (w_st == jtdp_pkg::ST_OK) begin
                    n_out.type_code = n_ret_type;
                end
            end
            n_mode        = 1'b0;
            n_phase       = jtdp_pkg::PH_IDLE;
            n_in_array    = 1'b0;
            n_position    = '0;
            n_first_error = '0;
            n_ret_type    = '0;
            n_ret_status  = '0;
            n_field_type  = '0;
        end else if (w_arg_done) begin
            w_emit          = 1'b1;
            n_out.type_code = w_typ;
            n_out.role      = jtdp_pkg::ROLE_ARG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_mode        <= 1'b0;
            r_phase       <= jtdp_pkg::PH_IDLE;
            r_in_array    <= 1'b0;
            r_position    <= '0;
            r_first_error <= '0;
            r_ret_type    <= '0;
            r_ret_status  <= '0;
            r_field_type  <= '0;
        end else begin
            if (w_in_load) begin
                r_in_valid <= i_valid;
            end
            if (w_advance) begin
                r_mode        <= n_mode;
                r_phase       <= n_phase;
                r_in_array    <= n_in_array;
                r_position    <= n_position;
                r_first_error <= n_first_error;
                r_ret_type    <= n_ret_type;
                r_ret_status  <= n_ret_status;
                r_field_type  <= n_field_type;
                r_out_valid   <= w_emit;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_load && i_valid) begin
            r_in <= i_data;
        end
        if (w_advance && w_emit) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

/* rtl/jtdp_checker.sv */
// Port-level checker for the descriptor parser, bound to the top level.
// Depends on jtdp_pkg for role, type and status codes.
`timescale 1ns / 1ps
`default_nettype none

module jtdp_checker (
    input wire             i_clk,
    input wire             i_rst_n,
    input wire             o_valid,
    input wire             i_stall,
    input jtdp_pkg::t_out  o_data
);

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled result changed");

    a_arg_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.final_res |->
            o_data.role == jtdp_pkg::ROLE_ARG && o_data.status == jtdp_pkg::ST_OK &&
            o_data.consumed_length == 8'd0 && o_data.type_code <= jtdp_pkg::TC_ARRAY)
        else $error("malformed argument transfer");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.final_res && o_data.status != jtdp_pkg::ST_OK |->
            o_data.type_code == 4'd0 && o_data.consumed_length == 8'd0 &&
            o_data.status <= jtdp_pkg::ST_MAX)
        else $error("error result carries type or length");

    a_final_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.final_res |->
            (o_data.role == jtdp_pkg::ROLE_FIELD ||
             (o_data.role == jtdp_pkg::ROLE_RETURN && o_data.consumed_length == 8'd0)) &&
            o_data.type_code <= jtdp_pkg::TC_MAX)
        else $error("bad closing result role");

endmodule

bind jvm_type_descriptor_parser jtdp_checker u_jtdp_checker (.*);

`default_nettype wire

/* bench/tb_jvm_type_descriptor_parser.sv */
// Self-checking testbench for jvm_type_descriptor_parser: a directed table, then random
// field and method descriptors, checked by a predictor of the parse or by table results.
// Depends on jtdp_pkg and the parser RTL only.
`timescale 1ns / 1ps

module tb_jvm_type_descriptor_parser;

    localparam int unsigned MAX_LEN = 255;
    localparam int RANDOM_ITEMS = 1500;
    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_CYCLES = 12;
    localparam int MAX_PRINTS = 100;

    localparam logic [3:0] TC_ERR   = 4'd0;
    localparam logic [3:0] TC_BYTE  = 4'd0;
    localparam logic [3:0] TC_CHAR  = 4'd1;
    localparam logic [3:0] TC_DBL   = 4'd2;
    localparam logic [3:0] TC_FLT   = 4'd3;
    localparam logic [3:0] TC_INT   = 4'd4;
    localparam logic [3:0] TC_LONG  = 4'd5;
    localparam logic [3:0] TC_SHORT = 4'd6;
    localparam logic [3:0] TC_BOOL  = 4'd7;
    localparam jtdp_pkg::t_out NO_RESULT = '0;

    localparam logic [7:0] PRIM_LETTERS [8] = '{
        jtdp_pkg::CH_BYTE, jtdp_pkg::CH_CHAR, jtdp_pkg::CH_DOUBLE, jtdp_pkg::CH_FLOAT,
        jtdp_pkg::CH_INT, jtdp_pkg::CH_LONG, jtdp_pkg::CH_SHORT, jtdp_pkg::CH_BOOL};
    localparam logic [7:0] SPECIALS [6] = '{
        jtdp_pkg::CH_LPAREN, jtdp_pkg::CH_RPAREN, jtdp_pkg::CH_SEMI, jtdp_pkg::CH_CLASS,
        jtdp_pkg::CH_ARRAY, jtdp_pkg::CH_VOID};

    typedef struct {
        jtdp_pkg::t_in  item;
        bit             typed;
        jtdp_pkg::t_out known;
    } t_row;

    logic           i_clk;
    logic           i_rst_n = 1'b0;
    logic           i_valid = 1'b0;
    jtdp_pkg::t_in  i_data = '0;
    logic           i_stall = 1'b0;
    logic           o_stall;
    logic           o_valid;
    jtdp_pkg::t_out o_data;

    jvm_type_descriptor_parser #(
        .MAX_LEN(MAX_LEN)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data(i_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data(o_data)
    );

    // Predictor state.
    logic             pm_method;
    jtdp_pkg::t_phase pm_phase;
    logic             pm_arr;
    logic [7:0]       pm_pos;
    logic [3:0]       pm_err;
    logic [3:0]       pm_ret_type;
    logic [3:0]       pm_ret_st;
    logic [3:0]       pm_field_type;

    jtdp_pkg::t_out pending_results[$];
    t_row           directed_rows[$];
    logic [7:0]     desc_chars[$];
    jtdp_pkg::t_in  desc_items[$];

    int cycle_count = 0;
    int error_count = 0;
    int xfer_in = 0;
    int xfer_out = 0;
    int desc_count = 0;
    int burst_left = 0;
    jtdp_pkg::t_out want_res;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void restart_parse();
        pm_method = 1'b0;
        pm_phase = jtdp_pkg::PH_IDLE;
        pm_arr = 1'b0;
        pm_pos = '0;
        pm_err = jtdp_pkg::ST_OK;
        pm_ret_type = '0;
        pm_ret_st = jtdp_pkg::ST_OK;
        pm_field_type = '0;
    endfunction

    function automatic logic [3:0] letter_type(input logic [7:0] c);
        case (c)
            jtdp_pkg::CH_BYTE:   return TC_BYTE;
            jtdp_pkg::CH_CHAR:   return TC_CHAR;
            jtdp_pkg::CH_DOUBLE: return TC_DBL;
            jtdp_pkg::CH_FLOAT:  return TC_FLT;
            jtdp_pkg::CH_INT:    return TC_INT;
            jtdp_pkg::CH_LONG:   return TC_LONG;
            jtdp_pkg::CH_SHORT:  return TC_SHORT;
            jtdp_pkg::CH_BOOL:   return TC_BOOL;
            default:             return jtdp_pkg::TC_NONE;
        endcase
    endfunction

    // Advances the parse by one transfer; returns 1 when a result is due.
    function automatic bit parse_step(input jtdp_pkg::t_in it, output jtdp_pkg::t_out res);
        logic [7:0] c;
        logic [3:0] lt;
        logic [3:0] st;
        logic [3:0] arg_type;
        bit arg_done;
        c = it.character;
        lt = letter_type(c);
        res = NO_RESULT;
        arg_type = '0;
        arg_done = 1'b0;
        if (pm_phase == jtdp_pkg::PH_IDLE) begin
            restart_parse();
            pm_method = it.mode;
            pm_phase = it.mode ? jtdp_pkg::PH_MSTART : jtdp_pkg::PH_FSTART;
        end
        if (!it.no_char && pm_method) begin
            case (pm_phase)
                jtdp_pkg::PH_MSTART: begin
                    if (c == jtdp_pkg::CH_LPAREN) begin
                        pm_phase = jtdp_pkg::PH_MARG;
                    end else begin
                        pm_err = jtdp_pkg::ST_NO_LBRACE;
                        pm_phase = jtdp_pkg::PH_HALT;
                    end
                end
                jtdp_pkg::PH_MARG, jtdp_pkg::PH_MELEM: begin
                    if (c == jtdp_pkg::CH_RPAREN) begin
                        if (pm_phase == jtdp_pkg::PH_MELEM) pm_err = jtdp_pkg::ST_BAD_ARRAY;
                        pm_arr = 1'b0;
                        pm_phase = jtdp_pkg::PH_RSTART;
                    end else if (lt != jtdp_pkg::TC_NONE) begin
                        arg_type = pm_arr ? jtdp_pkg::TC_ARRAY : lt;
                        arg_done = 1'b1;
                        pm_arr = 1'b0;
                        pm_phase = jtdp_pkg::PH_MARG;
                    end else if (c == jtdp_pkg::CH_CLASS) begin
                        pm_phase = jtdp_pkg::PH_MCLASS;
                    end else if (c == jtdp_pkg::CH_ARRAY) begin
                        pm_arr = 1'b1;
                        pm_phase = jtdp_pkg::PH_MELEM;
                    end else begin
                        pm_err = pm_arr ? jtdp_pkg::ST_BAD_ARRAY : jtdp_pkg::ST_UNRECOG;
                        pm_arr = 1'b0;
                        pm_phase = jtdp_pkg::PH_MSKIP;
                    end
                end
                jtdp_pkg::PH_MCLASS: begin
                    if (c == jtdp_pkg::CH_RPAREN) begin
                        pm_err = pm_arr ? jtdp_pkg::ST_BAD_ARRAY : jtdp_pkg::ST_BAD_REF;
                        pm_arr = 1'b0;
                        pm_phase = jtdp_pkg::PH_RSTART;
                    end else if (c == jtdp_pkg::CH_SEMI) begin
                        arg_type = pm_arr ? jtdp_pkg::TC_ARRAY : jtdp_pkg::TC_CLASS;
                        arg_done = 1'b1;
                        pm_arr = 1'b0;
                        pm_phase = jtdp_pkg::PH_MARG;
                    end
                end
                jtdp_pkg::PH_MSKIP: begin
                    if (c == jtdp_pkg::CH_RPAREN) pm_phase = jtdp_pkg::PH_RSTART;
                end
                jtdp_pkg::PH_RSTART, jtdp_pkg::PH_RELEM: begin
                    if (pm_phase == jtdp_pkg::PH_RSTART && c == jtdp_pkg::CH_VOID) begin
                        pm_ret_type = jtdp_pkg::TC_VOID;
                        pm_phase = jtdp_pkg::PH_RDONE;
                    end else if (lt != jtdp_pkg::TC_NONE) begin
                        pm_ret_type = pm_arr ? jtdp_pkg::TC_ARRAY : lt;
                        pm_phase = jtdp_pkg::PH_RDONE;
                    end else if (c == jtdp_pkg::CH_CLASS) begin
                        pm_phase = jtdp_pkg::PH_RCLASS;
                    end else if (c == jtdp_pkg::CH_ARRAY) begin
                        pm_arr = 1'b1;
                        pm_phase = jtdp_pkg::PH_RELEM;
                    end else begin
                        pm_ret_st = pm_arr ? jtdp_pkg::ST_BAD_ARRAY : jtdp_pkg::ST_UNRECOG;
                        pm_phase = jtdp_pkg::PH_HALT;
                    end
                end
                jtdp_pkg::PH_RCLASS: begin
                    if (c == jtdp_pkg::CH_SEMI) begin
                        pm_ret_type = pm_arr ? jtdp_pkg::TC_ARRAY : jtdp_pkg::TC_CLASS;
                        pm_phase = jtdp_pkg::PH_RDONE;
                    end
                end
                jtdp_pkg::PH_RDONE: begin
                    pm_ret_st = (pm_ret_type == jtdp_pkg::TC_VOID) ? jtdp_pkg::ST_UNRECOG
                                                                   : jtdp_pkg::ST_TAIL;
                    pm_phase = jtdp_pkg::PH_HALT;
                end
                default: ;
            endcase
        end else if (!it.no_char) begin
            if (pm_phase == jtdp_pkg::PH_FSTART || pm_phase == jtdp_pkg::PH_FELEM) begin
                if (pm_pos < MAX_LEN) pm_pos = pm_pos + 8'd1;
                if (lt != jtdp_pkg::TC_NONE) begin
                    pm_field_type = pm_arr ? jtdp_pkg::TC_ARRAY : lt;
                    pm_phase = jtdp_pkg::PH_FDONE;
                end else if (c == jtdp_pkg::CH_CLASS) begin
                    pm_phase = jtdp_pkg::PH_FCLASS;
                end else if (c == jtdp_pkg::CH_ARRAY) begin
                    pm_arr = 1'b1;
                    pm_phase = jtdp_pkg::PH_FELEM;
                end else begin
                    pm_err = pm_arr ? jtdp_pkg::ST_BAD_ARRAY : jtdp_pkg::ST_UNRECOG;
                    pm_phase = jtdp_pkg::PH_FERR;
                end
            end else if (pm_phase == jtdp_pkg::PH_FCLASS) begin
                if (pm_pos < MAX_LEN) pm_pos = pm_pos + 8'd1;
                if (c == jtdp_pkg::CH_SEMI) begin
                    pm_field_type = pm_arr ? jtdp_pkg::TC_ARRAY : jtdp_pkg::TC_CLASS;
                    pm_phase = jtdp_pkg::PH_FDONE;
                end
            end
        end
        if (it.last) begin
            res.final_res = 1'b1;
            if (!pm_method) begin
                case (pm_phase)
                    jtdp_pkg::PH_FSTART: st = jtdp_pkg::ST_EMPTY;
                    jtdp_pkg::PH_FELEM:  st = jtdp_pkg::ST_BAD_ARRAY;
                    jtdp_pkg::PH_FCLASS: st = pm_arr ? jtdp_pkg::ST_BAD_ARRAY
                                                     : jtdp_pkg::ST_BAD_REF;
                    jtdp_pkg::PH_FDONE:  st = jtdp_pkg::ST_OK;
                    default:             st = pm_err;
                endcase
                res.role = jtdp_pkg::ROLE_FIELD;
                if (st == jtdp_pkg::ST_OK) begin
                    res.type_code = pm_field_type;
                    res.consumed_length = pm_pos;
                end
            end else begin
                case (pm_phase)
                    jtdp_pkg::PH_MSTART: st = jtdp_pkg::ST_EMPTY;
                    jtdp_pkg::PH_MARG, jtdp_pkg::PH_MELEM,
                    jtdp_pkg::PH_MCLASS, jtdp_pkg::PH_MSKIP: st = jtdp_pkg::ST_NO_RBRACE;
                    jtdp_pkg::PH_RSTART: st = jtdp_pkg::ST_NO_RETURN;
                    jtdp_pkg::PH_RELEM:
                        st = (pm_err != jtdp_pkg::ST_OK) ? pm_err : jtdp_pkg::ST_BAD_ARRAY;
                    jtdp_pkg::PH_RCLASS:
                        st = (pm_err != jtdp_pkg::ST_OK) ? pm_err
                           : (pm_arr ? jtdp_pkg::ST_BAD_ARRAY : jtdp_pkg::ST_BAD_REF);
                    jtdp_pkg::PH_RDONE:  st = pm_err;
                    default:
                        st = (pm_err != jtdp_pkg::ST_OK) ? pm_err : pm_ret_st;
                endcase
                res.role = jtdp_pkg::ROLE_RETURN;
                if (st == jtdp_pkg::ST_OK) res.type_code = pm_ret_type;
            end
            res.status = st;
            restart_parse();
            return 1'b1;
        end
        if (arg_done) begin
            res.type_code = arg_type;
            res.role = jtdp_pkg::ROLE_ARG;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [7:0] name_char();
        logic [7:0] c;
        c = 8'($urandom);
        if (c == jtdp_pkg::CH_SEMI || c == jtdp_pkg::CH_RPAREN) c = c ^ 8'h40;
        return c;
    endfunction

    function automatic void append_char(input logic [7:0] c);
        desc_chars = {desc_chars, c};
    endfunction

    function automatic void add_type(input bit void_ok, input bit stretch);
        int depth;
        int len;
        if (void_ok && $urandom_range(0, 7) == 0) begin
            append_char(jtdp_pkg::CH_VOID);
            return;
        end
        depth = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        repeat (depth) append_char(jtdp_pkg::CH_ARRAY);
        if (stretch || $urandom_range(0, 2) == 0) begin
            len = (stretch || $urandom_range(0, 149) == 0) ? $urandom_range(260, 300)
                                                           : $urandom_range(0, 6);
            append_char(jtdp_pkg::CH_CLASS);
            repeat (len) append_char(name_char());
            append_char(jtdp_pkg::CH_SEMI);
        end else begin
            append_char(PRIM_LETTERS[$urandom_range(0, 7)]);
        end
    endfunction

    // Mostly well-formed descriptors with random content; a quarter get damaged.
    function automatic void build_descriptor(input bit stretch);
        bit as_method;
        int n;
        int cut;
        jtdp_pkg::t_in it;
        as_method = stretch ? 1'b0 : 1'($urandom_range(0, 1));
        desc_chars.delete();
        desc_items.delete();
        if (as_method) begin
            append_char(jtdp_pkg::CH_LPAREN);
            repeat ($urandom_range(0, 4)) add_type(1'b0, 1'b0);
            append_char(jtdp_pkg::CH_RPAREN);
            add_type(1'b1, 1'b0);
        end else begin
            add_type(1'b0, stretch);
        end
        if (!stretch && $urandom_range(0, 3) == 0) begin
            n = desc_chars.size();
            case ($urandom_range(0, 4))
                0: desc_chars[$urandom_range(0, n - 1)] = 8'($urandom);
                1: desc_chars[$urandom_range(0, n - 1)] = SPECIALS[$urandom_range(0, 5)];
                2: begin
                    cut = $urandom_range(0, n - 1);
                    while (desc_chars.size() > cut) void'(desc_chars.pop_back());
                end
                3: repeat ($urandom_range(1, 3)) append_char(8'($urandom));
                default: desc_chars.insert($urandom_range(0, n), SPECIALS[$urandom_range(0, 5)]);
            endcase
        end
        foreach (desc_chars[k]) begin
            if ($urandom_range(0, 19) == 0) begin
                it = jtdp_pkg::t_in'{1'($urandom), 8'($urandom), 1'b1, 1'b0};
                desc_items = {desc_items, it};
            end
            it = jtdp_pkg::t_in'{1'($urandom), desc_chars[k], 1'b0, 1'b0};
            desc_items = {desc_items, it};
        end
        if (desc_items.size() == 0) begin
            it = jtdp_pkg::t_in'{1'b0, 8'($urandom), 1'b1, 1'b0};
            desc_items = {desc_items, it};
        end
        desc_items[0].mode = as_method;
        desc_items[desc_items.size() - 1].last = 1'b1;
    endfunction

    task automatic send_item(input jtdp_pkg::t_in it, input bit use_known,
                             input jtdp_pkg::t_out known);
        int gap;
        jtdp_pkg::t_out res;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_data <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        xfer_in++;
        if (parse_step(it, res)) pending_results = {pending_results, (use_known ? known : res)};
    endtask

    task automatic report_mismatch(input string what, input int got, input int want_v);
        if (error_count < MAX_PRINTS)
            $display("%0t: mismatch in %s: got %0d, wanted %0d", $time, what, got, want_v);
        error_count++;
    endtask

    // Receiver stall pattern and run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        case (cycle_count[9:8])
            2'd0:    i_stall <= 1'b0;
            2'd1:    i_stall <= ($urandom_range(0, 2) == 0);
            2'd2:    i_stall <= ($urandom_range(0, 3) != 0);
            default: i_stall <= (cycle_count[1:0] == 2'd0);
        endcase
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            xfer_out++;
            if (pending_results.size() == 0) begin
                report_mismatch("result transfer with nothing pending", o_data.status, 0);
            end else begin
                want_res = pending_results.pop_front();
                if (o_data.type_code !== want_res.type_code)
                    report_mismatch("type_code", o_data.type_code, want_res.type_code);
                if (o_data.role !== want_res.role)
                    report_mismatch("role", o_data.role, want_res.role);
                if (o_data.consumed_length !== want_res.consumed_length)
                    report_mismatch("consumed_length", o_data.consumed_length,
                                    want_res.consumed_length);
                if (o_data.status !== want_res.status)
                    report_mismatch("status", o_data.status, want_res.status);
                if (o_data.final_res !== want_res.final_res)
                    report_mismatch("final_res", o_data.final_res, want_res.final_res);
            end
        end
    end

    initial begin
        int counted;
        restart_parse();
        counted = 0;
        directed_rows = '{
            '{jtdp_pkg::t_in'{1'b0, 8'h00, 1'b1, 1'b1}, 1'b1,
              jtdp_pkg::t_out'{TC_ERR, jtdp_pkg::ROLE_FIELD, 8'd0,
                               jtdp_pkg::ST_EMPTY, 1'b1}},
            '{jtdp_pkg::t_in'{1'b1, 8'h00, 1'b1, 1'b0}, 1'b0, NO_RESULT},
            '{jtdp_pkg::t_in'{1'b0, 8'hFF, 1'b1, 1'b1}, 1'b1,
              jtdp_pkg::t_out'{TC_ERR, jtdp_pkg::ROLE_RETURN, 8'd0,
                               jtdp_pkg::ST_EMPTY, 1'b1}},
            '{jtdp_pkg::t_in'{1'b1, jtdp_pkg::CH_LPAREN, 1'b0, 1'b0}, 1'b0, NO_RESULT},
            '{jtdp_pkg::t_in'{1'b0, jtdp_pkg::CH_BYTE,   1'b0, 1'b0}, 1'b0, NO_RESULT},
            '{jtdp_pkg::t_in'{1'b1, jtdp_pkg::CH_ARRAY,  1'b0, 1'b0}, 1'b0, NO_RESULT},
            '{jtdp_pkg::t_in'{1'b0, jtdp_pkg::CH_CHAR,   1'b0, 1'b0}, 1'b0, NO_RESULT},
            '{jtdp_pkg::t_in'{1'b0, jtdp_pkg::CH_RPAREN, 1'b0, 1'b0}, 1'b0, NO_RESULT},
            '{jtdp_pkg::t_in'{1'b1, jtdp_pkg::CH_VOID,   1'b0, 1'b0}, 1'b0, NO_RESULT},
            '{jtdp_pkg::t_in'{1'b0, 8'hFF, 1'b0, 1'b1}, 1'b1,
              jtdp_pkg::t_out'{TC_ERR, jtdp_pkg::ROLE_RETURN, 8'd0,
                               jtdp_pkg::ST_UNRECOG, 1'b1}},
            '{jtdp_pkg::t_in'{1'b1, jtdp_pkg::CH_LPAREN, 1'b0, 1'b0}, 1'b0, NO_RESULT},
            '{jtdp_pkg::t_in'{1'b0, jtdp_pkg::CH_CLASS,  1'b0, 1'b0}, 1'b0, NO_RESULT},
            '{jtdp_pkg::t_in'{1'b1, jtdp_pkg::CH_RPAREN, 1'b0, 1'b0}, 1'b0, NO_RESULT},
            '{jtdp_pkg::t_in'{1'b0, jtdp_pkg::CH_DOUBLE, 1'b0, 1'b1}, 1'b1,
              jtdp_pkg::t_out'{TC_ERR, jtdp_pkg::ROLE_RETURN, 8'd0,
                               jtdp_pkg::ST_BAD_REF, 1'b1}},
            '{jtdp_pkg::t_in'{1'b0, jtdp_pkg::CH_LONG,   1'b0, 1'b0}, 1'b0, NO_RESULT},
            '{jtdp_pkg::t_in'{1'b1, 8'h00, 1'b0, 1'b1}, 1'b1,
              jtdp_pkg::t_out'{TC_LONG, jtdp_pkg::ROLE_FIELD, 8'd1,
                               jtdp_pkg::ST_OK, 1'b1}},
            '{jtdp_pkg::t_in'{1'b1, jtdp_pkg::CH_LPAREN, 1'b0, 1'b0}, 1'b0, NO_RESULT},
            '{jtdp_pkg::t_in'{1'b0, jtdp_pkg::CH_SHORT,  1'b0, 1'b0}, 1'b0, NO_RESULT},
            '{jtdp_pkg::t_in'{1'b1, jtdp_pkg::CH_FLOAT,  1'b0, 1'b1}, 1'b1,
              jtdp_pkg::t_out'{TC_ERR, jtdp_pkg::ROLE_RETURN, 8'd0,
                               jtdp_pkg::ST_NO_RBRACE, 1'b1}},
            '{jtdp_pkg::t_in'{1'b1, jtdp_pkg::CH_LPAREN, 1'b0, 1'b0}, 1'b0, NO_RESULT},
            '{jtdp_pkg::t_in'{1'b1, jtdp_pkg::CH_RPAREN, 1'b0, 1'b0}, 1'b0, NO_RESULT},
            '{jtdp_pkg::t_in'{1'b0, jtdp_pkg::CH_INT,    1'b0, 1'b0}, 1'b0, NO_RESULT},
            '{jtdp_pkg::t_in'{1'b0, jtdp_pkg::CH_BOOL,   1'b0, 1'b1}, 1'b1,
              jtdp_pkg::t_out'{TC_ERR, jtdp_pkg::ROLE_RETURN, 8'd0,
                               jtdp_pkg::ST_TAIL, 1'b1}},
            '{jtdp_pkg::t_in'{1'b0, jtdp_pkg::CH_ARRAY,  1'b0, 1'b0}, 1'b0, NO_RESULT},
            '{jtdp_pkg::t_in'{1'b0, jtdp_pkg::CH_CLASS,  1'b0, 1'b0}, 1'b0, NO_RESULT},
            '{jtdp_pkg::t_in'{1'b0, jtdp_pkg::CH_SEMI,   1'b0, 1'b1}, 1'b1,
              jtdp_pkg::t_out'{jtdp_pkg::TC_ARRAY, jtdp_pkg::ROLE_FIELD, 8'd3,
                               jtdp_pkg::ST_OK, 1'b1}}
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r])
            send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].known);

        while (counted < RANDOM_ITEMS) begin
            build_descriptor(desc_count < 2);
            desc_count++;
            foreach (desc_items[k]) begin
                send_item(desc_items[k], 1'b0, NO_RESULT);
                if (!desc_items[k].no_char || desc_items[k].last) counted++;
            end
        end
        i_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Parsed %0d directed rows and %0d random descriptors in %0d cycles.",
                 directed_rows.size(), desc_count, cycle_count);
        $display("Input transfers %0d, result transfers %0d, mismatches %0d.",
                 xfer_in, xfer_out, error_count);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
